// ===== rtl/chp_pkg.sv =====
// ----------------------------------------------------------------------------
// chp_pkg
// Shared types and constants for the image file header parser: the input and
// result transaction structs, byte classes, error codes and format constants.
// ----------------------------------------------------------------------------
package chp_pkg;

	// one byte of the file
	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_t;

	// classification and status for one byte
	typedef struct packed {
		logic [3:0]  byte_kind;
		logic [63:0] field_value;
		logic        field_done;
		logic        header_done;
		logic [63:0] bytes_seen;
		logic [1:0]  error_code;
	} out_t;

	// byte classes
	localparam logic [3:0] KIND_MAGIC    = 4'd0;
	localparam logic [3:0] KIND_HSIZE    = 4'd1;
	localparam logic [3:0] KIND_CSIZE    = 4'd2;
	localparam logic [3:0] KIND_WIDTH    = 4'd3;
	localparam logic [3:0] KIND_HEIGHT   = 4'd4;
	localparam logic [3:0] KIND_CAPTION  = 4'd5;
	localparam logic [3:0] KIND_NEW_TAG  = 4'd6;
	localparam logic [3:0] KIND_TAG_CHAR = 4'd7;
	localparam logic [3:0] KIND_TAG_END  = 4'd8;
	localparam logic [3:0] KIND_CONTENT  = 4'd9;

	// error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_MAGIC  = 2'd1;
	localparam logic [1:0] ERR_LENGTH = 2'd2;
	localparam logic [1:0] ERR_EARLY  = 2'd3;

	// format constants
	localparam logic [31:0] MAGIC_WORD     = 32'h4349_4646;
	localparam int          MAGIC_BYTES    = 4;
	localparam int          FIELD_BYTES    = 8;
	localparam logic [2:0]  MAGIC_LAST_IDX = 3'(MAGIC_BYTES - 1);
	localparam logic [2:0]  FIELD_LAST_IDX = 3'(FIELD_BYTES - 1);
	localparam logic [7:0]  NEWLINE_BYTE   = 8'h0A;
	localparam logic [7:0]  NUL_BYTE       = 8'h00;

endpackage

// ===== rtl/chp_parse_step.sv =====
// ----------------------------------------------------------------------------
// chp_parse_step
// Parser state and the per-byte decision logic. The result for the presented
// byte is combinational; state advances when step_en is high.
// ----------------------------------------------------------------------------
module chp_parse_step (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step_en,
	input  chp_pkg::in_t  item,
	output chp_pkg::out_t result
);

	typedef enum logic [2:0] {
		PH_MAGIC  = 3'd0,
		PH_HSIZE  = 3'd1,
		PH_CSIZE  = 3'd2,
		PH_WIDTH  = 3'd3,
		PH_HEIGHT = 3'd4,
		PH_CAPT   = 3'd5,
		PH_TAG    = 3'd6,
		PH_DONE   = 3'd7
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [2:0]  idx_q, idx_n;
	logic [31:0] magic_q, magic_n;
	logic [63:0] accum_q, accum_n;
	logic [63:0] hsize_q, hsize_n;
	logic [63:0] count_q, count_n;
	logic        tag_q, tag_n;
	logic [1:0]  err_q, err_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_MAGIC;
			idx_q   <= '0;
			magic_q <= '0;
			accum_q <= '0;
			hsize_q <= '0;
			count_q <= '0;
			tag_q   <= 1'b0;
			err_q   <= chp_pkg::ERR_NONE;
		end else if (step_en) begin
			phase_q <= phase_n;
			idx_q   <= idx_n;
			magic_q <= magic_n;
			accum_q <= accum_n;
			hsize_q <= hsize_n;
			count_q <= count_n;
			tag_q   <= tag_n;
			err_q   <= err_n;
		end
	end

	always_comb begin
		logic [7:0]  b;
		logic [63:0] count_inc;
		logic [63:0] accum_sum;
		logic [3:0]  kind;
		logic [63:0] fval;
		logic        fdone;
		logic        hdone;

		b         = item.data_byte;
		count_inc = count_q + 64'd1;
		accum_sum = accum_q | ({56'd0, b} << {idx_q, 3'b000});

		phase_n = phase_q;
		idx_n   = idx_q;
		magic_n = magic_q;
		accum_n = accum_q;
		hsize_n = hsize_q;
		count_n = count_q;
		tag_n   = tag_q;
		err_n   = err_q;
		kind    = chp_pkg::KIND_CONTENT;
		fval    = '0;
		fdone   = 1'b0;
		hdone   = 1'b0;

		// once an error is set the parser freezes
		if (err_q == chp_pkg::ERR_NONE) begin
			case (phase_q)
				PH_MAGIC: begin
					kind    = chp_pkg::KIND_MAGIC;
					count_n = count_inc;
					magic_n = {magic_q[23:0], b};
					if (idx_q == chp_pkg::MAGIC_LAST_IDX) begin
						idx_n   = '0;
						phase_n = PH_HSIZE;
						if (magic_n != chp_pkg::MAGIC_WORD)
							err_n = chp_pkg::ERR_MAGIC;
					end else begin
						idx_n = idx_q + 3'd1;
					end
				end
				PH_HSIZE, PH_CSIZE, PH_WIDTH, PH_HEIGHT: begin
					count_n = count_inc;
					idx_n   = idx_q + 3'd1;
					case (phase_q)
						PH_HSIZE: begin
							kind = chp_pkg::KIND_HSIZE;
						end
						PH_CSIZE: begin
							kind = chp_pkg::KIND_CSIZE;
						end
						PH_WIDTH: begin
							kind = chp_pkg::KIND_WIDTH;
						end
						default: begin
							kind = chp_pkg::KIND_HEIGHT;
						end
					endcase
					if (idx_q == chp_pkg::FIELD_LAST_IDX) begin
						fdone   = 1'b1;
						fval    = accum_sum;
						accum_n = '0;
						case (phase_q)
							PH_HSIZE: begin
								hsize_n = accum_sum;
								phase_n = PH_CSIZE;
							end
							PH_CSIZE: begin
								phase_n = PH_WIDTH;
							end
							PH_WIDTH: begin
								phase_n = PH_HEIGHT;
							end
							default: begin
								phase_n = PH_CAPT;
							end
						endcase
					end else begin
						accum_n = accum_sum;
					end
				end
				PH_CAPT: begin
					kind    = chp_pkg::KIND_CAPTION;
					count_n = count_inc;
					if (count_inc >= hsize_q)
						err_n = chp_pkg::ERR_LENGTH;
					else if (b == chp_pkg::NEWLINE_BYTE)
						phase_n = PH_TAG;
				end
				PH_TAG: begin
					count_n = count_inc;
					if (b == chp_pkg::NUL_BYTE) begin
						kind  = chp_pkg::KIND_TAG_END;
						tag_n = 1'b0;
						if (count_inc == hsize_q) begin
							phase_n = PH_DONE;
							hdone   = 1'b1;
						end
					end else begin
						kind  = tag_q ? chp_pkg::KIND_TAG_CHAR : chp_pkg::KIND_NEW_TAG;
						tag_n = 1'b1;
					end
					if (!hdone && count_inc >= hsize_q)
						err_n = chp_pkg::ERR_LENGTH;
				end
				default: begin
					kind = chp_pkg::KIND_CONTENT;
				end
			endcase
			if (item.last_byte && err_n == chp_pkg::ERR_NONE && phase_n != PH_DONE)
				err_n = chp_pkg::ERR_EARLY;
		end

		result.byte_kind   = kind;
		result.field_value = fval;
		result.field_done  = fdone;
		result.header_done = hdone;
		result.bytes_seen  = count_n;
		result.error_code  = err_n;
	end

endmodule

// ===== rtl/ciff_header_parser.sv =====
// ----------------------------------------------------------------------------
// ciff_header_parser
// Byte-serial parser for an image file header: checks the magic, assembles
// the four little-endian 64-bit fields and classifies every byte.
// ----------------------------------------------------------------------------
// usage
//   in channel: one file byte per transaction (in_valid/in_ready/in_data),
//     with last_byte marking the final byte of the file
//   out channel: one result transaction per input byte (out_valid/out_ready/
//     out_data): byte class, completed field value, header done flag, header
//     byte count and the sticky error code
//   path: an accepted byte sits in the input stage and is decoded into the
//     result register once that register is free; its result is offered
//     from the result register
//   throughput: one byte per cycle unless out_ready stalls; the only loop is the
//     parser state update, a 64-bit increment and compare plus a byte-lane merge
//   stall: when out_ready is low the result register holds, the input stage
//     keeps one byte, and in_ready drops only when both are full
//   reset: arst_n clears both stages and the parser returns to the magic
//     phase with counts and errors cleared
//   errors: the first error freezes the parser until reset; later bytes are
//     reported as content with the frozen count and stored error
// ----------------------------------------------------------------------------
module ciff_header_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  chp_pkg::in_t  in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output chp_pkg::out_t out_data
);

	// input stage
	logic         valid_s1;
	chp_pkg::in_t item_s1;

	// result stage
	logic          out_valid_q;
	chp_pkg::out_t result_q;

	chp_pkg::out_t step_result;
	logic          out_free;
	logic          step;

	// result register can take a new transaction this cycle
	assign out_free = !out_valid_q || out_ready;
	// the buffered byte is decoded and moved into the result register
	assign step     = valid_s1 && out_free;
	// input stage takes a byte when empty or draining this cycle
	assign in_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			item_s1 <= in_data;
	end

	chp_parse_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (step),
		.item    (item_s1),
		.result  (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step)
			result_q <= step_result;
	end

	assign out_valid = out_valid_q;
	assign out_data  = result_q;

endmodule
